// ===== rtl/ahc_pkg.sv =====
`default_nettype none

package ahc_pkg;

    // Default store geometry
    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_DIM  = 64;

    // Index fields in the command word are sized for the largest geometry
    localparam int CMD_ROW_W = 9;
    localparam int CMD_DIM_W = 8;

    localparam logic [17:0] LOG2E_Q16   = 18'd94548;
    localparam int          ROUND_HALF  = 32768;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam int          EXP_SHIFT_LIMIT = 17;

    // Register reset values
    localparam logic [5:0]  RST_SEQ_LENGTH  = 6'd32;
    localparam logic [6:0]  RST_HEAD_DIM    = 7'd64;
    localparam logic [6:0]  RST_VALUE_DIM   = 7'd64;
    localparam logic [15:0] RST_SCORE_SCALE = 16'd8192;

    typedef enum logic [1:0] {
        CFG_SEQ_LENGTH  = 2'd0,
        CFG_HEAD_DIM    = 2'd1,
        CFG_VALUE_DIM   = 2'd2,
        CFG_SCORE_SCALE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_WRITE_Q = 2'd0,
        OP_WRITE_K = 2'd1,
        OP_WRITE_V = 2'd2,
        OP_COMPUTE = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         operation;
        logic [4:0]         row_index;
        logic [5:0]         col_index;
        logic signed [15:0] element;
    } t_in_word;

    typedef struct packed {
        logic [4:0]         out_row;
        logic [5:0]         out_col;
        logic signed [15:0] out_value;
        logic               last;
    } t_out_word;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_MAC,
        DP_SC_LO,
        DP_SC_HI,
        DP_SC_WR,
        DP_EX_D,
        DP_EX_MULU,
        DP_EX_U,
        DP_EX_MUL,
        DP_EX_UPD,
        DP_EX_WR,
        DP_DIV,
        DP_W_MUL,
        DP_W_WR,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op                 op;
        logic                   first;
        logic                   mac_wv;
        logic                   last;
        logic [4:0]             row;
        logic [CMD_ROW_W-1:0]   j;
        logic [CMD_DIM_W-1:0]   l;
        logic [3:0]             bitn;
    } t_dp_cmd;

    // 2^-(2^-k) in Q0.16, k = 1..16
    function automatic logic [15:0] frac_tab(input logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'd0:  v = 16'd46341;
            4'd1:  v = 16'd55109;
            4'd2:  v = 16'd60097;
            4'd3:  v = 16'd62757;
            4'd4:  v = 16'd64132;
            4'd5:  v = 16'd64830;
            4'd6:  v = 16'd65182;
            4'd7:  v = 16'd65359;
            4'd8:  v = 16'd65447;
            4'd9:  v = 16'd65492;
            4'd10: v = 16'd65514;
            4'd11: v = 16'd65525;
            4'd12: v = 16'd65530;
            4'd13: v = 16'd65533;
            default: v = 16'd65535;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ahc_datapath.sv =====
`default_nettype none

module ahc_datapath #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_DIM  = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ahc_pkg::t_dp_cmd  i_cmd,
    input  wire ahc_pkg::t_in_word i_word,
    input  wire logic [15:0]       i_score_scale,
    output logic                   o_strobe,
    output ahc_pkg::t_out_word     o_word
);
    import ahc_pkg::*;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEPTH  = MAX_ROWS * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MX     = (MAX_ROWS > MAX_DIM) ? MAX_ROWS : MAX_DIM;
    localparam int ACC_W  = 34 + ((MX > 1) ? $clog2(MX) : 0);
    localparam int MUL_AW = (ACC_W - 19 > 21) ? ACC_W - 19 : 21;
    localparam int MUL_PW = MUL_AW + 18;
    localparam int SCW    = ACC_W + 18;
    localparam int SUM_W  = 18 + ROW_W;

    logic signed [15:0] q_mem [DEPTH];
    logic signed [15:0] k_mem [DEPTH];
    logic signed [15:0] v_mem [DEPTH];
    logic signed [ACC_W-1:0] score_mem [MAX_ROWS];
    logic [16:0]        weight_mem [MAX_ROWS];

    logic signed [15:0]       r_q_rd, r_k_rd, r_v_rd;
    logic signed [ACC_W-1:0]  r_score_rd;
    logic [16:0]              r_w_rd;

    logic r_mac_v1, r_mac_f1, r_mac_wv1, r_mac_v2, r_mac_f2;

    logic signed [MUL_AW-1:0] mul_a;
    logic signed [17:0]       mul_b;
    logic signed [MUL_PW-1:0] r_prod, r_lo;
    logic signed [MUL_PW-1:0] prod_rnd;

    logic signed [ACC_W-1:0]  r_acc, r_max;
    logic signed [SCW-1:0]    sc_full;
    logic signed [ACC_W-1:0]  score;
    logic signed [ACC_W:0]    diff;
    logic [ACC_W:0]           r_d;
    logic                     r_big;
    logic [20:0]              r_u;
    logic [16:0]              r_e, e_fin;
    logic [SUM_W-1:0]         r_sum, r_rem;
    logic [SUM_W:0]           rem_sh;
    logic                     div_ge;
    logic [16:0]              r_recip;
    logic signed [ACC_W-1:0]  out_rnd;
    logic signed [ACC_W-17:0] out_v;
    logic signed [15:0]       out_sat;

    logic [ADDR_W-1:0] q_addr, kv_addr, ld_addr;
    logic [ROW_W-1:0]  j_idx;
    logic              ld_ok;

    assign j_idx   = ROW_W'(i_cmd.j);
    assign q_addr  = ADDR_W'(32'(i_cmd.row) * MAX_DIM + 32'(i_cmd.l));
    assign kv_addr = ADDR_W'(32'(i_cmd.j) * MAX_DIM + 32'(i_cmd.l));
    assign ld_addr = ADDR_W'(32'(i_word.row_index) * MAX_DIM + 32'(i_word.col_index));
    assign ld_ok   = (32'(i_word.row_index) < MAX_ROWS) && (32'(i_word.col_index) < MAX_DIM);

    // Stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_LOAD && ld_ok) begin
            case (t_op'(i_word.operation))
                OP_WRITE_Q: q_mem[ld_addr] <= i_word.element;
                OP_WRITE_K: k_mem[ld_addr] <= i_word.element;
                OP_WRITE_V: v_mem[ld_addr] <= i_word.element;
                default: ;
            endcase
        end
        r_q_rd <= q_mem[q_addr];
        r_k_rd <= k_mem[kv_addr];
        r_v_rd <= v_mem[kv_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_SC_WR) begin
            score_mem[j_idx] <= score;
        end
        r_score_rd <= score_mem[j_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_EX_WR) begin
            weight_mem[j_idx] <= e_fin;
        end else if (i_cmd.op == DP_W_WR) begin
            weight_mem[j_idx] <= prod_rnd[32:16];
        end
        r_w_rd <= weight_mem[j_idx];
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_mac_v1) begin
            if (r_mac_wv1) begin
                mul_a = MUL_AW'($signed({1'b0, r_w_rd}));
                mul_b = 18'(r_v_rd);
            end else begin
                mul_a = MUL_AW'(r_q_rd);
                mul_b = 18'(r_k_rd);
            end
        end else begin
            case (i_cmd.op)
                DP_SC_LO: begin
                    mul_a = MUL_AW'($signed({1'b0, r_acc[18:0]}));
                    mul_b = $signed({2'b0, i_score_scale});
                end
                DP_SC_HI: begin
                    mul_a = MUL_AW'($signed(r_acc[ACC_W-1:19]));
                    mul_b = $signed({2'b0, i_score_scale});
                end
                DP_EX_MULU: begin
                    mul_a = MUL_AW'($signed({1'b0, r_d[19:0]}));
                    mul_b = $signed(LOG2E_Q16);
                end
                DP_EX_MUL: begin
                    mul_a = MUL_AW'($signed({1'b0, r_e}));
                    mul_b = $signed({2'b0, frac_tab(4'd15 - i_cmd.bitn)});
                end
                DP_W_MUL: begin
                    mul_a = MUL_AW'($signed({1'b0, r_w_rd}));
                    mul_b = $signed({1'b0, r_recip});
                end
                default: ;
            endcase
        end
    end

    assign prod_rnd = r_prod + MUL_PW'(ROUND_HALF);
    assign sc_full  = (SCW'(r_prod) <<< 19) + SCW'(r_lo) + SCW'(ROUND_HALF);
    assign score    = sc_full[ACC_W+15:16];
    assign diff     = (ACC_W+1)'(r_max) - (ACC_W+1)'(r_score_rd);
    assign e_fin    = (r_big || (32'(r_u[20:16]) >= EXP_SHIFT_LIMIT)) ? '0 : (r_e >> r_u[20:16]);
    assign rem_sh   = i_cmd.first ? (SUM_W+1)'(1) : {r_rem, 1'b0};
    assign div_ge   = rem_sh >= {1'b0, r_sum};
    assign out_rnd  = r_acc + ACC_W'(ROUND_HALF);
    assign out_v    = out_rnd[ACC_W-1:16];

    always_comb begin
        if (out_v > (ACC_W-16)'(32767)) begin
            out_sat = 16'sh7FFF;
        end else if (out_v < -(ACC_W-16)'(32768)) begin
            out_sat = -16'sh8000;
        end else begin
            out_sat = out_v[15:0];
        end
    end

    // MAC pipeline tags: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_v1 <= 1'b0;
            r_mac_v2 <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_mac_v1 <= (i_cmd.op == DP_MAC);
            r_mac_v2 <= r_mac_v1;
            o_strobe <= (i_cmd.op == DP_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mac_f1  <= i_cmd.first;
        r_mac_wv1 <= i_cmd.mac_wv;
        r_mac_f2  <= r_mac_f1;
        r_prod    <= mul_a * mul_b;
        if (r_mac_v2) begin
            r_acc <= r_mac_f2 ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
        case (i_cmd.op)
            DP_SC_HI: r_lo <= r_prod;
            DP_SC_WR: begin
                if (i_cmd.first || score > r_max) begin
                    r_max <= score;
                end
            end
            DP_EX_D: begin
                r_d   <= diff;
                r_big <= |diff[ACC_W:20];
            end
            DP_EX_U: begin
                r_u <= prod_rnd[36:16];
                r_e <= ONE_Q16;
            end
            DP_EX_UPD: begin
                if (r_u[i_cmd.bitn]) begin
                    r_e <= prod_rnd[32:16];
                end
            end
            DP_EX_WR: r_sum <= i_cmd.first ? SUM_W'(e_fin) : r_sum + SUM_W'(e_fin);
            DP_DIV: begin
                r_rem   <= div_ge ? SUM_W'(rem_sh - {1'b0, r_sum}) : SUM_W'(rem_sh);
                r_recip <= {r_recip[15:0], div_ge};
            end
            DP_EMIT: begin
                o_word.out_row   <= i_cmd.row;
                o_word.out_col   <= 6'(i_cmd.l);
                o_word.out_value <= out_sat;
                o_word.last      <= i_cmd.last;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ahc_controller.sv =====
`default_nettype none

module ahc_controller #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_DIM  = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire ahc_pkg::t_in_word               i_word,
    input  wire logic [$clog2(MAX_ROWS+1)-1:0]   i_n,
    input  wire logic [$clog2(MAX_DIM+1)-1:0]    i_hd,
    input  wire logic [$clog2(MAX_DIM+1)-1:0]    i_vd,
    output logic                                 o_busy,
    output ahc_pkg::t_dp_cmd                     o_cmd
);
    import ahc_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    typedef enum logic [19:0] {
        S_IDLE     = 20'h00001,
        S_DOT      = 20'h00002,
        S_DOT_WAIT = 20'h00004,
        S_SC_LO    = 20'h00008,
        S_SC_HI    = 20'h00010,
        S_SC_WR    = 20'h00020,
        S_EX_RD    = 20'h00040,
        S_EX_D     = 20'h00080,
        S_EX_MULU  = 20'h00100,
        S_EX_U     = 20'h00200,
        S_EX_MUL   = 20'h00400,
        S_EX_UPD   = 20'h00800,
        S_EX_WR    = 20'h01000,
        S_DIV      = 20'h02000,
        S_W_RD     = 20'h04000,
        S_W_MUL    = 20'h08000,
        S_W_WR     = 20'h10000,
        S_OUT_MAC  = 20'h20000,
        S_OUT_WAIT = 20'h40000,
        S_OUT      = 20'h80000
    } t_state;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_j, n_j;
    logic [DIM_W-1:0] r_l, n_l;
    logic [3:0]       r_b, n_b;
    logic [5:0]       r_k, n_k;
    logic             r_wait, n_wait;
    logic [4:0]       r_row, n_row;
    logic             j_end, l_end, c_end;

    assign j_end  = (32'(r_j) == 32'(i_n) - 1);
    assign l_end  = (32'(r_l) == 32'(i_hd) - 1);
    assign c_end  = (32'(r_l) == 32'(i_vd) - 1);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_l     = r_l;
        n_b     = r_b;
        n_k     = r_k;
        n_wait  = r_wait;
        n_row   = r_row;
        o_cmd        = '0;
        o_cmd.op     = DP_NONE;
        o_cmd.row    = r_row;
        o_cmd.j      = CMD_ROW_W'(r_j);
        o_cmd.l      = CMD_DIM_W'(r_l);
        o_cmd.bitn   = r_b;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (t_op'(i_word.operation) != OP_COMPUTE) begin
                        o_cmd.op = DP_LOAD;
                    end else if (32'(i_word.row_index) < 32'(i_n)) begin
                        n_row   = i_word.row_index;
                        n_j     = '0;
                        n_l     = '0;
                        n_state = S_DOT;
                    end
                end
            end
            S_DOT: begin
                o_cmd.op    = DP_MAC;
                o_cmd.first = (r_l == '0);
                if (l_end) begin
                    n_l     = '0;
                    n_wait  = 1'b0;
                    n_state = S_DOT_WAIT;
                end else begin
                    n_l = r_l + 1'b1;
                end
            end
            S_DOT_WAIT: begin
                n_wait = 1'b1;
                if (r_wait) begin
                    n_state = S_SC_LO;
                end
            end
            S_SC_LO: begin
                o_cmd.op = DP_SC_LO;
                n_state  = S_SC_HI;
            end
            S_SC_HI: begin
                o_cmd.op = DP_SC_HI;
                n_state  = S_SC_WR;
            end
            S_SC_WR: begin
                o_cmd.op    = DP_SC_WR;
                o_cmd.first = (r_j == '0);
                if (j_end) begin
                    n_j     = '0;
                    n_state = S_EX_RD;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_DOT;
                end
            end
            S_EX_RD: n_state = S_EX_D;
            S_EX_D: begin
                o_cmd.op = DP_EX_D;
                n_state  = S_EX_MULU;
            end
            S_EX_MULU: begin
                o_cmd.op = DP_EX_MULU;
                n_state  = S_EX_U;
            end
            S_EX_U: begin
                o_cmd.op = DP_EX_U;
                n_b      = 4'd15;
                n_state  = S_EX_MUL;
            end
            S_EX_MUL: begin
                o_cmd.op = DP_EX_MUL;
                n_state  = S_EX_UPD;
            end
            S_EX_UPD: begin
                o_cmd.op = DP_EX_UPD;
                if (r_b == 4'd0) begin
                    n_state = S_EX_WR;
                end else begin
                    n_b     = r_b - 1'b1;
                    n_state = S_EX_MUL;
                end
            end
            S_EX_WR: begin
                o_cmd.op    = DP_EX_WR;
                o_cmd.first = (r_j == '0);
                if (j_end) begin
                    n_j     = '0;
                    n_k     = 6'd32;
                    n_state = S_DIV;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_EX_RD;
                end
            end
            S_DIV: begin
                o_cmd.op    = DP_DIV;
                o_cmd.first = (r_k == 6'd32);
                if (r_k == 6'd0) begin
                    n_state = S_W_RD;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            S_W_RD: n_state = S_W_MUL;
            S_W_MUL: begin
                o_cmd.op = DP_W_MUL;
                n_state  = S_W_WR;
            end
            S_W_WR: begin
                o_cmd.op = DP_W_WR;
                if (j_end) begin
                    n_j     = '0;
                    n_l     = '0;
                    n_state = S_OUT_MAC;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_W_RD;
                end
            end
            S_OUT_MAC: begin
                o_cmd.op     = DP_MAC;
                o_cmd.mac_wv = 1'b1;
                o_cmd.first  = (r_j == '0);
                if (j_end) begin
                    n_j     = '0;
                    n_wait  = 1'b0;
                    n_state = S_OUT_WAIT;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_OUT_WAIT: begin
                n_wait = 1'b1;
                if (r_wait) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.op   = DP_EMIT;
                o_cmd.last = c_end;
                if (c_end) begin
                    n_state = S_IDLE;
                end else begin
                    n_l     = r_l + 1'b1;
                    n_state = S_OUT_MAC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_l    <= n_l;
        r_b    <= n_b;
        r_k    <= n_k;
        r_wait <= n_wait;
        r_row  <= n_row;
    end

endmodule

`default_nettype wire

// ===== rtl/attention_head_core_unit.sv =====
`default_nettype none

// Single-head attention core. Load words (query, key, value element) never
// raise busy. A compute word for query row r raises busy while it works
// through n rows, head length hd and value length vd. Every product, the
// score scaling, the base-2 exponential steps and the weight normalization
// pass through the one shared multiplier, and a 33-step restoring divider
// forms the reciprocal of the sum. Results leave as vd words, one per value
// column, each valid for exactly one cycle while o_strobe is high; the
// receiver cannot stall them, so it must take every strobed word. Compute
// words for rows at or beyond the clamped seq_length, and load words outside
// the stores, are dropped without results. The user must write configuration
// only while busy is low and no word is pending; the block itself does not
// enforce it.
module attention_head_core_unit #(
    parameter int MAX_ROWS = ahc_pkg::DEF_MAX_ROWS,
    parameter int MAX_DIM  = ahc_pkg::DEF_MAX_DIM
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire ahc_pkg::t_in_word    i_word,
    output logic                      o_strobe,
    output ahc_pkg::t_out_word        o_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data
);
    import ahc_pkg::*;

    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int DIM_CNT_W = $clog2(MAX_DIM + 1);

    logic [5:0]  r_seq_length;
    logic [6:0]  r_head_dim;
    logic [6:0]  r_value_dim;
    logic [15:0] r_score_scale;

    logic [ROW_CNT_W-1:0] n_rows;
    logic [DIM_CNT_W-1:0] hd_len, vd_len;

    t_dp_cmd cmd;

    // Configuration registers: write-only, no wait
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_length  <= RST_SEQ_LENGTH;
            r_head_dim    <= RST_HEAD_DIM;
            r_value_dim   <= RST_VALUE_DIM;
            r_score_scale <= RST_SCORE_SCALE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SEQ_LENGTH:  r_seq_length  <= i_cfg_data[5:0];
                CFG_HEAD_DIM:    r_head_dim    <= i_cfg_data[6:0];
                CFG_VALUE_DIM:   r_value_dim   <= i_cfg_data[6:0];
                CFG_SCORE_SCALE: r_score_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp dimensions: zero acts as one, oversize acts as the store limit
    always_comb begin
        if (r_seq_length == '0) begin
            n_rows = ROW_CNT_W'(1);
        end else if (32'(r_seq_length) > MAX_ROWS) begin
            n_rows = ROW_CNT_W'(MAX_ROWS);
        end else begin
            n_rows = ROW_CNT_W'(r_seq_length);
        end
        if (r_head_dim == '0) begin
            hd_len = DIM_CNT_W'(1);
        end else if (32'(r_head_dim) > MAX_DIM) begin
            hd_len = DIM_CNT_W'(MAX_DIM);
        end else begin
            hd_len = DIM_CNT_W'(r_head_dim);
        end
        if (r_value_dim == '0) begin
            vd_len = DIM_CNT_W'(1);
        end else if (32'(r_value_dim) > MAX_DIM) begin
            vd_len = DIM_CNT_W'(MAX_DIM);
        end else begin
            vd_len = DIM_CNT_W'(r_value_dim);
        end
    end

    // Sequencer: walks dot products, softmax steps and value sums
    ahc_controller #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_DIM  (MAX_DIM)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_word  (i_word),
        .i_n     (n_rows),
        .i_hd    (hd_len),
        .i_vd    (vd_len),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // Stores, shared multiplier, accumulator, divider and output register
    ahc_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_DIM  (MAX_DIM)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_word        (i_word),
        .i_score_scale (r_score_scale),
        .o_strobe      (o_strobe),
        .o_word        (o_word)
    );

endmodule

`default_nettype wire
